// ===== rtl/core/slrg_pkg.sv =====
// Shared constants for the stepper line ramp generator.
package slrg_pkg;

	localparam int AXES           = 4;
	localparam int AXIS_IDX_BITS  = $clog2(AXES);
	localparam int COUNT_BITS_DEF = 24;
	localparam int DIR_BITS       = 4;
	localparam int PER_BITS       = 23;
	localparam int FIX_BITS       = 32;
	localparam int FRAC_BITS      = 8;
	localparam int DIVD_BITS      = FIX_BITS + 1;

	localparam logic [FIX_BITS-1:0] ROUND_HALF = 32'd128;
	localparam logic [FIX_BITS-1:0] DIV_STEP   = 32'd4;
	localparam logic [FIX_BITS-1:0] DIV_K_ONE  = 32'd1;
	localparam logic [FIX_BITS-1:0] DIV_K_FIVE = 32'd5;
	localparam logic [PER_BITS-1:0] PER_MAX    = {PER_BITS{1'b1}};
	localparam logic [PER_BITS-1:0] PER_LOAD   = 23'd1;

	localparam logic [1:0] PH_ACCEL = 2'd0;
	localparam logic [1:0] PH_RUN   = 2'd1;
	localparam logic [1:0] PH_DECEL = 2'd2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

endpackage

// ===== rtl/core/stepper_line_ramp_generator_unit.sv =====
// Top level: move sequencer, ramp state and result register.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+-----------------------------------------
//  cmd     | cmd_valid | cmd_stall | command, stop_now, move setup fields
//  res     | res_valid | res_stall | step_mask, dir_mask, step_period, ...
//
// Load, idle tick and stop: accept, then write the result.
// Active tick: accept, the axis pass over all axes, the ramp check, the ramp
// update check where it applies, the divide (33-bit restoring divider, one bit a
// cycle) and period update when the ramp divides, then step count and result write.
// No command is taken until the word of the previous one is in the result
// register; a stalled result only delays the write-back of the next one.
// Reset clears the sequencer's ramp and move state (not the axis accumulators); no clearing pass.
module stepper_line_ramp_generator_unit #(
	parameter int COUNT_BITS = slrg_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic                          command,
	input  logic                          stop_now,
	input  logic [COUNT_BITS-1:0]         move_steps,
	input  logic [COUNT_BITS-1:0]         axis_x_steps,
	input  logic [COUNT_BITS-1:0]         axis_y_steps,
	input  logic [COUNT_BITS-1:0]         axis_z_steps,
	input  logic [COUNT_BITS-1:0]         axis_e_steps,
	input  logic [slrg_pkg::DIR_BITS-1:0] dir_bits,
	input  logic [slrg_pkg::PER_BITS-1:0] start_period,
	input  logic [slrg_pkg::PER_BITS-1:0] min_period,
	input  logic [COUNT_BITS-1:0]         mid_step,
	input  logic [1:0]                    start_phase,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [slrg_pkg::AXES-1:0]     step_mask,
	output logic [slrg_pkg::DIR_BITS-1:0] dir_mask,
	output logic [slrg_pkg::PER_BITS-1:0] step_period,
	output logic [1:0]                    ramp_phase,
	output logic                          motors_on,
	output logic                          move_done
);
	import slrg_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_AXIS = 8'b0000_0010,
		ST_RAMP = 8'b0000_0100,
		ST_UPD  = 8'b0000_1000,
		ST_DIV  = 8'b0001_0000,
		ST_PER  = 8'b0010_0000,
		ST_FIN  = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} seq_state_t;

	seq_state_t              state_q;
	logic [AXIS_IDX_BITS-1:0] axis_idx_q;

	logic [COUNT_BITS-1:0]   steps_q;
	logic [COUNT_BITS-1:0]   len_q;
	logic [COUNT_BITS-1:0]   mid_q;
	logic [COUNT_BITS-1:0]   decel_q;
	logic [FIX_BITS-1:0]     pf_q;
	logic [FIX_BITS-1:0]     rdiv_q;
	logic [PER_BITS-1:0]     cur_q;
	logic [PER_BITS-1:0]     floor_q;
	logic [1:0]              phase_q;
	logic [DIR_BITS-1:0]     dir_q;
	logic                    active_q;

	logic [AXES-1:0]         mask_q;
	logic                    wload_q;
	logic                    wdone_q;

	logic                    res_valid_q;
	logic [AXES-1:0]         step_mask_q;
	logic [DIR_BITS-1:0]     dir_mask_q;
	logic [PER_BITS-1:0]     step_period_q;
	logic [1:0]              ramp_phase_q;
	logic                    motors_on_q;
	logic                    move_done_q;

	logic                    cmd_acc;
	logic                    load_acc;
	logic [AXES-1:0][COUNT_BITS-1:0] incr_in;
	logic                    hit;
	logic                    div_start;
	logic [FIX_BITS-1:0]     div_quo;
	logic                    div_done;
	logic [FIX_BITS-1:0]     rdiv_next;
	logic [FIX_BITS-1:0]     s_minus_len;
	logic [FIX_BITS-1:0]     div_k1;
	logic [FIX_BITS-1:0]     div_k5;
	logic [COUNT_BITS-1:0]   len_m1;
	logic [COUNT_BITS-1:0]   steps_next;
	logic [FIX_BITS-1:0]     rsum;
	logic [FIX_BITS-1:0]     per_raw;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign load_acc  = cmd_acc && (command == CMD_LOAD);

	assign incr_in[0] = axis_x_steps;
	assign incr_in[1] = axis_y_steps;
	assign incr_in[2] = axis_z_steps;
	assign incr_in[3] = axis_e_steps;

	assign s_minus_len = FIX_BITS'(steps_q) - FIX_BITS'(len_q);
	assign div_k1      = {s_minus_len[FIX_BITS-3:0], 2'b00} + DIV_K_ONE;
	assign div_k5      = {s_minus_len[FIX_BITS-3:0], 2'b00} + DIV_K_FIVE;
	assign rdiv_next   = rdiv_q + DIV_STEP;
	assign len_m1      = len_q - {{(COUNT_BITS-1){1'b0}}, 1'b1};
	assign steps_next  = steps_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
	assign rsum        = pf_q + ROUND_HALF;
	assign per_raw     = {{FRAC_BITS{rsum[FIX_BITS-1]}}, rsum[FIX_BITS-1:FRAC_BITS]};
	assign div_start   = (state_q == ST_UPD) && (steps_q != len_m1);

	slrg_axis #(
		.COUNT_BITS(COUNT_BITS)
	) u_axis (
		.clk     (clk),
		.load    (load_acc),
		.len     (load_acc ? move_steps : len_q),
		.incr_in (incr_in),
		.step_en (state_q == ST_AXIS),
		.idx     (axis_idx_q),
		.step_hit(hit)
	);

	slrg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({pf_q, 1'b0}),
		.divisor (rdiv_next),
		.quotient(div_quo),
		.done    (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_idx_q  <= '0;
			steps_q     <= '0;
			len_q       <= '0;
			mid_q       <= '0;
			decel_q     <= '0;
			pf_q        <= '0;
			rdiv_q      <= DIV_K_ONE;
			cur_q       <= '0;
			floor_q     <= '0;
			phase_q     <= PH_ACCEL;
			dir_q       <= '0;
			active_q    <= 1'b0;
			mask_q      <= '0;
			wload_q     <= 1'b0;
			wdone_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && state_q != ST_EMIT)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						mask_q  <= '0;
						wload_q <= (command == CMD_LOAD);
						if (command == CMD_LOAD) begin
							len_q    <= move_steps;
							mid_q    <= mid_step;
							floor_q  <= min_period;
							cur_q    <= start_period;
							dir_q    <= dir_bits;
							phase_q  <= start_phase;
							pf_q     <= FIX_BITS'({start_period, {FRAC_BITS{1'b0}}});
							rdiv_q   <= DIV_K_ONE;
							decel_q  <= '0;
							steps_q  <= '0;
							active_q <= (move_steps != '0);
							wdone_q  <= (move_steps == '0);
							state_q  <= ST_EMIT;
						end else if (!active_q) begin
							wdone_q <= 1'b0;
							state_q <= ST_EMIT;
						end else if (stop_now) begin
							active_q <= 1'b0;
							wdone_q  <= 1'b1;
							state_q  <= ST_EMIT;
						end else begin
							wdone_q    <= 1'b0;
							axis_idx_q <= '0;
							state_q    <= ST_AXIS;
						end
					end
				end
				ST_AXIS: begin
					mask_q[axis_idx_q] <= hit;
					axis_idx_q         <= axis_idx_q + 1'b1;
					if (axis_idx_q == AXIS_IDX_BITS'(AXES - 1))
						state_q <= ST_RAMP;
				end
				ST_RAMP: begin
					case (phase_q)
						PH_ACCEL: begin
							if (steps_q == mid_q) begin
								phase_q <= PH_DECEL;
								if (len_q[0]) begin
									rdiv_q  <= div_k5;
									state_q <= ST_FIN;
								end else begin
									rdiv_q  <= div_k1;
									state_q <= ST_UPD;
								end
							end else begin
								state_q <= ST_UPD;
							end
						end
						PH_DECEL: state_q <= ST_UPD;
						PH_RUN: begin
							if (steps_q == decel_q) begin
								phase_q <= PH_DECEL;
								rdiv_q  <= div_k5;
							end
							state_q <= ST_FIN;
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_UPD: begin
					if (div_start) begin
						rdiv_q  <= rdiv_next;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						pf_q    <= pf_q - div_quo;
						state_q <= ST_PER;
					end
				end
				ST_PER: begin
					if (per_raw <= FIX_BITS'(floor_q)) begin
						phase_q <= PH_RUN;
						decel_q <= len_q - steps_q;
						cur_q   <= floor_q;
					end else if (per_raw > FIX_BITS'(PER_MAX)) begin
						cur_q <= PER_MAX;
					end else begin
						cur_q <= per_raw[PER_BITS-1:0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					steps_q <= steps_next;
					if (steps_next == len_q) begin
						active_q <= 1'b0;
						wdone_q  <= 1'b1;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && (!res_valid_q || !res_stall)) begin
			step_mask_q   <= mask_q;
			dir_mask_q    <= dir_q;
			step_period_q <= wload_q ? PER_LOAD : cur_q;
			ramp_phase_q  <= phase_q;
			motors_on_q   <= active_q;
			move_done_q   <= wdone_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign step_mask   = step_mask_q;
	assign dir_mask    = dir_mask_q;
	assign step_period = step_period_q;
	assign ramp_phase  = ramp_phase_q;
	assign motors_on   = motors_on_q;
	assign move_done   = move_done_q;

	a_tick_steps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && command == CMD_TICK && active_q && !stop_now |=> state_q == ST_AXIS)
		else $error("active tick did not start stepping");
	a_divisor_form: assert property (@(posedge clk) disable iff (!arst_n)
		rdiv_q[1:0] == 2'b01)
		else $error("ramp divisor not 1 modulo 4");
	a_done_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(motors_on && move_done))
		else $error("move done with motors on");
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_done)
		else $error("divider finished outside a ramp update");

endmodule

// ===== rtl/core/slrg_div.sv =====
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
module slrg_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [slrg_pkg::DIVD_BITS-1:0] dividend,
	input  logic [slrg_pkg::FIX_BITS-1:0]  divisor,
	output logic [slrg_pkg::FIX_BITS-1:0]  quotient,
	output logic                           done
);
	import slrg_pkg::*;

	localparam int DIV_STEPS = DIVD_BITS;
	localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

	typedef enum logic [2:0] {
		DV_IDLE = 3'b001,
		DV_RUN  = 3'b010,
		DV_FIX  = 3'b100
	} dv_state_t;

	dv_state_t             st_q;
	logic [FIX_BITS-1:0]   rem_q;
	logic [DIVD_BITS-1:0]  num_q;
	logic [FIX_BITS-1:0]   den_q;
	logic                  neg_q;
	logic                  zero_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [FIX_BITS-1:0]   quo_q;
	logic                  done_q;

	logic [DIVD_BITS-1:0]  trial;
	logic [DIVD_BITS:0]    diff;
	logic                  ge;

	assign trial = {rem_q, num_q[DIVD_BITS-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = ~diff[DIVD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == DV_FIX);
			case (st_q)
				DV_IDLE: begin
					if (start) begin
						cnt_q <= CNT_BITS'(DIV_STEPS);
						st_q  <= DV_RUN;
					end
				end
				DV_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_BITS'(1))
						st_q <= DV_FIX;
				end
				DV_FIX: begin
					st_q <= DV_IDLE;
				end
				default: st_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == DV_IDLE && start) begin
			num_q  <= dividend[DIVD_BITS-1] ? -dividend : dividend;
			den_q  <= divisor[FIX_BITS-1] ? -divisor : divisor;
			neg_q  <= dividend[DIVD_BITS-1] ^ divisor[FIX_BITS-1];
			zero_q <= (divisor == '0);
			rem_q  <= '0;
		end else if (st_q == DV_RUN) begin
			num_q <= {num_q[DIVD_BITS-2:0], ge};
			rem_q <= ge ? diff[FIX_BITS-1:0] : trial[FIX_BITS-1:0];
		end else if (st_q == DV_FIX) begin
			if (zero_q)
				quo_q <= '0;
			else if (neg_q)
				quo_q <= -num_q[FIX_BITS-1:0];
			else
				quo_q <= num_q[FIX_BITS-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

	a_fix_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == DV_FIX |=> done_q)
		else $error("divider skipped done");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done longer than one cycle");
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == DV_IDLE && start |=> st_q == DV_RUN && !done_q)
		else $error("divider did not start");

endmodule

// ===== rtl/core/slrg_axis.sv =====
// Axis accumulator bank with one shared add/compare, one axis per cycle while step_en is high.
module slrg_axis #(
	parameter int COUNT_BITS = slrg_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               load,
	input  logic [COUNT_BITS-1:0]              len,
	input  logic [slrg_pkg::AXES-1:0][COUNT_BITS-1:0] incr_in,
	input  logic                               step_en,
	input  logic [slrg_pkg::AXIS_IDX_BITS-1:0] idx,
	output logic                               step_hit
);
	import slrg_pkg::*;

	localparam int ACC_BITS = COUNT_BITS + 1;

	logic [ACC_BITS-1:0]   accum_q [AXES];
	logic [COUNT_BITS-1:0] incr_q  [AXES];

	logic [ACC_BITS-1:0]   sum;
	logic [ACC_BITS-1:0]   sum_sub;

	assign sum      = accum_q[idx] + {1'b0, incr_q[idx]};
	assign sum_sub  = sum - {1'b0, len};
	assign step_hit = (sum > {1'b0, len});

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < AXES; i++) begin
				accum_q[i] <= {2'b00, len[COUNT_BITS-1:1]};
				incr_q[i]  <= incr_in[i];
			end
		end else if (step_en) begin
			accum_q[idx] <= step_hit ? sum_sub : sum;
		end
	end

endmodule
